>>> hdl/sppc_pkg.sv
// Shared constants, codes and helper functions for the sampling PC profile histogram.
// Depends on nothing; imported by the top level and the checker, not by sppc_ram.
package sppc_pkg;

  // Histogram geometry and tick scaling
  localparam int NUM_BINS     = 4096;
  localparam int BIN_SIZE     = 16;                 // power of two
  localparam int CREDIT_DEPTH = 10;
  localparam int DELTA_SHIFT  = 13;

  localparam int BIN_SHIFT = $clog2(BIN_SIZE);
  localparam int BIN_AW    = $clog2(NUM_BINS);
  localparam int BIN_CW    = 17;                   // wide enough to hold NUM_BINS itself

  // Field widths
  localparam int ACTION_W = 3;
  localparam int NOW_W    = 63;
  localparam int OFFSET_W = 16;
  localparam int DEPTH_W  = 4;
  localparam int RIDX_W   = 12;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 32;
  localparam int DELTA_W  = 31;

  // Stream widths
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 72;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_START = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STOPPED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_DELTA = 2'd2;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  // Saturating counter add
  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [DELTA_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + (COUNT_W+1)'(b);
    sat_add = s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

  // Scaled and saturated tick delta from the raw cycle difference
  function automatic logic [DELTA_W-1:0] scale_delta(input logic [NOW_W-1:0] diff);
    logic [NOW_W-1:0] sh;
    sh = diff >> DELTA_SHIFT;
    scale_delta = (|sh[NOW_W-1:DELTA_W]) ? {DELTA_W{1'b1}} : sh[DELTA_W-1:0];
  endfunction

endpackage

>>> hdl/sppc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used twice by the top level for the bin counters.
module sppc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sampling_pc_profile_histogram_top.sv
// Top level of the sampling PC profile histogram: sequencer, timebase and bin update.
// Depends on sppc_pkg and sppc_ram.
//
//   channel | direction | tuser        | tdata (low bit up)                       | tlast
//   in_     | slave     | action[2:0]  | now, code_offset, frame_depth, read_index | last_frame
//   out_    | master    | -            | status, top_count, all_count             | -
//
// Each item has two steps: the accept cycle issues the bin read and the
// timebase difference, and the S_EXEC state does the saturating update and write-back.
// The sequencer holds one item at a time, so a read and its write-back never
// overlap with those of another item.
// After reset and after a clear action a pass over all NUM_BINS (4096) bins zeroes
// them; in_tready stays low during the pass.
// A result waits in the output register; the next item is taken meanwhile, and
// an item stalls in its update cycle only while the output register is full.
module sampling_pc_profile_histogram_top
  import sppc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [62:0] now, [78:63] code_offset, [82:79] frame_depth, [94:83] read_index
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] action
  input  logic [ACTION_W-1:0]   in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] status, [33:2] top_count, [65:34] all_count
  output logic [OUT_DATA_W-1:0] out_tdata
);

  state_t state_r, state_nxt;

  // Input fields
  logic [NOW_W-1:0]    in_now;
  logic [OFFSET_W-1:0] in_offset;
  logic [DEPTH_W-1:0]  in_depth;
  logic [RIDX_W-1:0]   in_ridx;
  assign in_now    = in_tdata[NOW_W-1:0];
  assign in_offset = in_tdata[NOW_W+OFFSET_W-1:NOW_W];
  assign in_depth  = in_tdata[NOW_W+OFFSET_W+DEPTH_W-1:NOW_W+OFFSET_W];
  assign in_ridx   = in_tdata[NOW_W+OFFSET_W+DEPTH_W+RIDX_W-1:NOW_W+OFFSET_W+DEPTH_W];

  // Timebase state
  logic [NOW_W-1:0]   last_time_r, last_time_nxt;
  logic               running_r, running_nxt;
  logic [DELTA_W-1:0] tick_delta_r, tick_delta_nxt;

  // Item held for the update cycle
  logic [ACTION_W-1:0] action_r;
  logic [NOW_W-1:0]    now_r;
  logic [NOW_W-1:0]    diff_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic                last_r;
  logic [BIN_AW-1:0]   addr_r;
  logic                addr_ok_r;

  // Clear sweep
  logic [BIN_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Memory ports
  logic               ram_we, ram_re;
  logic [BIN_AW-1:0]  ram_waddr, ram_raddr;
  logic [COUNT_W-1:0] all_wdata, top_wdata, all_rdata, top_rdata;
  logic               top_we;

  logic accept;
  logic proceed;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign proceed   = !out_valid_r || out_tready;

  // Bin address and range check at accept
  logic [OFFSET_W-1:0] bin_full;
  logic                bin_ok, ridx_ok;
  assign bin_full  = in_offset >> BIN_SHIFT;
  assign bin_ok    = BIN_CW'(bin_full) < BIN_CW'(NUM_BINS);
  assign ridx_ok   = BIN_CW'(in_ridx) < BIN_CW'(NUM_BINS);
  assign ram_re    = accept;
  assign ram_raddr = (in_tuser == ACT_READ) ? BIN_AW'(in_ridx) : BIN_AW'(bin_full);

  // Capture the item and the timebase difference
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r  <= in_tuser;
      now_r     <= in_now;
      diff_r    <= in_now - last_time_r;
      depth_r   <= in_depth;
      last_r    <= in_tlast;
      addr_r    <= ram_raddr;
      addr_ok_r <= (in_tuser == ACT_READ) ? ridx_ok : bin_ok;
    end
  end

  // Update cycle: timebase, bin credit, result
  logic [DELTA_W-1:0] delta_use;
  logic               credit;
  assign delta_use = (depth_r == '0) ? scale_delta(diff_r) : tick_delta_r;
  assign credit    = running_r && (delta_use != '0) &&
                     (depth_r < DEPTH_W'(CREDIT_DEPTH)) && addr_ok_r;

  always_comb begin
    state_nxt      = state_r;
    last_time_nxt  = last_time_r;
    running_nxt    = running_r;
    tick_delta_nxt = tick_delta_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    top_we         = 1'b0;
    ram_waddr      = addr_r;
    all_wdata      = sat_add(all_rdata, delta_use);
    top_wdata      = sat_add(top_rdata, delta_use);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (proceed) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          unique case (action_r)
            ACT_START: begin
              if (!running_r) begin
                last_time_nxt = diff_r;
                running_nxt   = 1'b1;
              end
            end
            ACT_STOP: begin
              if (running_r) begin
                last_time_nxt = diff_r;
                running_nxt   = 1'b0;
              end
            end
            ACT_TICK: begin
              if (!running_r) begin
                out_data_nxt[STATUS_W-1:0] = ST_STOPPED;
              end else begin
                if (depth_r == '0) begin
                  tick_delta_nxt = delta_use;
                end
                if (delta_use == '0) begin
                  out_data_nxt[STATUS_W-1:0] = ST_ZERO_DELTA;
                end else if (last_r) begin
                  last_time_nxt = now_r;
                end
                ram_we = credit;
                top_we = credit && (depth_r == '0);
                if (last_r) begin
                  tick_delta_nxt = '0;
                end
              end
            end
            ACT_READ: begin
              if (addr_ok_r) begin
                out_data_nxt[STATUS_W+COUNT_W-1:STATUS_W]           = top_rdata;
                out_data_nxt[STATUS_W+2*COUNT_W-1:STATUS_W+COUNT_W] = all_rdata;
              end
            end
            ACT_CLEAR: begin
              state_nxt   = S_CLEAR;
              clr_cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_CLEAR: begin
        // Zero one bin per cycle
        ram_we      = 1'b1;
        top_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        all_wdata   = '0;
        top_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BIN_AW'(NUM_BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      last_time_r  <= '0;
      running_r    <= 1'b0;
      tick_delta_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      last_time_r  <= last_time_nxt;
      running_r    <= running_nxt;
      tick_delta_r <= tick_delta_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Bin counter memories
  sppc_ram #(.DEPTH(NUM_BINS), .WIDTH(COUNT_W)) u_all_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (all_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (all_rdata)
  );

  sppc_ram #(.DEPTH(NUM_BINS), .WIDTH(COUNT_W)) u_top_ram (
    .clk   (clk),
    .we    (top_we),
    .waddr (ram_waddr),
    .wdata (top_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (top_rdata)
  );

endmodule

>>> hdl/sppc_checker.sv
// Port-level checks for the sampling PC profile histogram, bound to the top level.
// Depends on sppc_pkg and sampling_pc_profile_histogram_top.
module sppc_checker
  import sppc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [ACTION_W-1:0]   in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Reset starts the bin wipe, so no beat is taken right after it
  a_reset_wipe: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  // One item in flight: no beat taken in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while an item is in flight");

  // A clear action keeps the input closed once the wipe is due; the check samples a single point, not the whole wipe
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ACT_CLEAR |-> ##2 !in_tready)
    else $error("input ready during bin wipe");

  // Ignored frames never carry counts
  a_status_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[STATUS_W-1:0] != ST_OK |->
      out_tdata[STATUS_W+2*COUNT_W-1:STATUS_W] == '0)
    else $error("nonzero counts with an error status");

endmodule

bind sampling_pc_profile_histogram_top sppc_checker u_sppc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
